// ----- rtl/ltc_pkg.sv -----
// shared types, constants and character class functions for the token classifier
package ltc_pkg;

    localparam int PREFIX_DEPTH = 6;
    localparam int NUM_KEYWORDS = 8;

    // result kind codes
    localparam logic [2:0] KIND_KEYWORD    = 3'd0;
    localparam logic [2:0] KIND_INTEGER    = 3'd1;
    localparam logic [2:0] KIND_IDENTIFIER = 3'd2;
    localparam logic [2:0] KIND_INVALID    = 3'd3;
    localparam logic [2:0] KIND_OPERATOR   = 3'd4;

    // keyword text, byte 0 in the low bits, padded with zero bytes
    localparam logic [PREFIX_DEPTH-1:0][7:0] KW_TEXT [NUM_KEYWORDS] = '{
        {8'd0, 8'd0, 8'd0, "t", "n", "i"},
        {8'd0, "t", "a", "o", "l", "f"},
        {8'd0, 8'd0, 8'd0, 8'd0, "f", "i"},
        {8'd0, 8'd0, "e", "s", "l", "e"},
        {8'd0, "e", "l", "i", "h", "w"},
        {"n", "r", "u", "t", "e", "r"},
        {8'd0, 8'd0, "r", "a", "h", "c"},
        {8'd0, 8'd0, "d", "i", "o", "v"}
    };

    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4, 3'd4
    };

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] token_start;
        logic [5:0]  token_length;
        logic [2:0]  keyword_index;
        logic [7:0]  operator_char;
        logic        too_long;
        logic        last;
    } res_t;

    function automatic logic is_delim(input logic [7:0] c);
        logic r;
        unique case (c)
            " ", ",", ";", "(", ")", "{", "}", "[", "]", "=", "<", ">": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "=") || (c == "<") || (c == ">");
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

// ----- rtl/ltc_scanner.sv -----
// token scanner: token state registers, classification of closed tokens and operator results
module ltc_scanner
    import ltc_pkg::*;
#(
    parameter int TOKEN_LIMIT   = 49,
    parameter int POSITION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] text_byte,
    output logic [1:0] res_count,
    output res_t       res0,
    output res_t       res1
);

    localparam int LEN_BITS = $clog2(TOKEN_LIMIT + 1);
    localparam int LW = (LEN_BITS > 6) ? LEN_BITS : 6;
    localparam int PW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [POSITION_BITS-1:0]          position_reg, position_next;
    logic [POSITION_BITS-1:0]          start_reg, start_next;
    logic [LEN_BITS-1:0]               len_reg, len_next;
    logic [PREFIX_DEPTH-1:0][7:0]      prefix_reg, prefix_next;
    logic                              all_digits_reg, all_digits_next;
    logic                              ident_reg, ident_next;
    logic                              overflow_reg, overflow_next;

    logic          is_tok_char;
    logic          has_tok;
    logic          has_op;
    logic          found;
    logic [2:0]    kw_idx;
    logic [2:0]    tok_kind;
    logic [LW-1:0] len_ext;
    logic [PW-1:0] start_ext;
    logic [PW-1:0] pos_ext;
    res_t          tok_res;
    res_t          op_res;

    assign is_tok_char = (text_byte != 8'd0) && !is_delim(text_byte);
    assign has_tok     = !is_tok_char && (len_reg != '0);
    assign has_op      = !is_tok_char && (text_byte != 8'd0) && is_oper(text_byte);

    // keyword match over the stored prefix
    always_comb
    begin
        found  = 1'b0;
        kw_idx = 3'd0;
        for (int i = 0; i < NUM_KEYWORDS; i++)
        begin
            if (!found && !overflow_reg && (len_reg == LEN_BITS'(KW_LEN[i])) &&
                (prefix_reg == KW_TEXT[i]))
            begin
                found  = 1'b1;
                kw_idx = 3'(i);
            end
        end
    end

    // token class, in priority order
    always_comb
    begin
        priority if (found)
            tok_kind = KIND_KEYWORD;
        else if (all_digits_reg)
            tok_kind = KIND_INTEGER;
        else if (ident_reg)
            tok_kind = KIND_IDENTIFIER;
        else
            tok_kind = KIND_INVALID;
    end

    assign len_ext   = LW'(len_reg);
    assign start_ext = PW'(start_reg);
    assign pos_ext   = PW'(position_reg);

    // result items for a closing byte
    always_comb
    begin
        tok_res.kind          = tok_kind;
        tok_res.token_start   = start_ext[15:0];
        tok_res.token_length  = len_ext[5:0];
        tok_res.keyword_index = kw_idx;
        tok_res.operator_char = 8'd0;
        tok_res.too_long      = overflow_reg;
        tok_res.last          = !has_op;

        op_res.kind          = KIND_OPERATOR;
        op_res.token_start   = pos_ext[15:0];
        op_res.token_length  = 6'd1;
        op_res.keyword_index = 3'd0;
        op_res.operator_char = text_byte;
        op_res.too_long      = 1'b0;
        op_res.last          = 1'b1;

        res0      = has_tok ? tok_res : op_res;
        res1      = op_res;
        res_count = {1'b0, has_tok} + {1'b0, has_op};
    end

    // next token state
    always_comb
    begin
        position_next   = position_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        prefix_next     = prefix_reg;
        all_digits_next = all_digits_reg;
        ident_next      = ident_reg;
        overflow_next   = overflow_reg;
        if (take)
        begin
            if (is_tok_char)
            begin
                if (len_reg == '0)
                begin
                    start_next = position_reg;
                    ident_next = is_ident_start(text_byte);
                end
                for (int j = 0; j < PREFIX_DEPTH; j++)
                begin
                    if (len_reg == LEN_BITS'(j))
                        prefix_next[j] = text_byte;
                end
                if (!is_digit(text_byte))
                    all_digits_next = 1'b0;
                if (len_reg < LEN_BITS'(TOKEN_LIMIT))
                    len_next = len_reg + 1'b1;
                else
                    overflow_next = 1'b1;
                position_next = position_reg + 1'b1;
            end
            else
            begin
                len_next        = '0;
                prefix_next     = '0;
                all_digits_next = 1'b1;
                ident_next      = 1'b0;
                overflow_next   = 1'b0;
                position_next   = (text_byte == 8'd0) ? '0 : position_reg + 1'b1;
            end
        end
    end

    // token state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            start_reg      <= '0;
            len_reg        <= '0;
            prefix_reg     <= '0;
            all_digits_reg <= 1'b1;
            ident_reg      <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            position_reg   <= position_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
            prefix_reg     <= prefix_next;
            all_digits_reg <= all_digits_next;
            ident_reg      <= ident_next;
            overflow_reg   <= overflow_next;
        end
    end

endmodule

// ----- rtl/ltc_result_fifo.sv -----
// four-entry result queue taking up to two results per cycle
module ltc_result_fifo
    import ltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  res_t       push0,
    input  res_t       push1,
    input  logic       pop,
    output res_t       head,
    output logic       head_valid,
    output logic       room2
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    res_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign room2      = (count_reg <= (AW+1)'(DEPTH - 2));

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push_count) - (AW+1)'(pop);
    end

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_ptr_reg + 1'b1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/lexical_token_classifier_top.sv -----
// Byte-serial lexer top level: scanner plus result queue.
// A result enters the result queue when the byte that closes it is transferred.
// Throughput: one text byte per cycle while the four-entry result queue has two free
// entries; results leave one per cycle with result_ready high, so two-result bytes can
// hold it off. Reset (rst_n, async, active low) clears position, token state and queue.
module lexical_token_classifier_top
    import ltc_pkg::*;
#(
    parameter int TOKEN_LIMIT   = 49,
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  kind,
    output logic [15:0] token_start,
    output logic [5:0]  token_length,
    output logic [2:0]  keyword_index,
    output logic [7:0]  operator_char,
    output logic        too_long,
    output logic        last
);

    logic       take;
    logic       room2;
    logic [1:0] res_count;
    logic [1:0] push_count;
    res_t       res0;
    res_t       res1;
    res_t       head;

    assign text_ready = room2;
    assign take       = text_valid && text_ready;
    assign push_count = take ? res_count : 2'd0;

    // token scanning and classification
    ltc_scanner #(
        .TOKEN_LIMIT   (TOKEN_LIMIT),
        .POSITION_BITS (POSITION_BITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .text_byte (text_byte),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    // result queue
    ltc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (result_valid && result_ready),
        .head       (head),
        .head_valid (result_valid),
        .room2      (room2)
    );

    // result fields
    assign kind          = head.kind;
    assign token_start   = head.token_start;
    assign token_length  = head.token_length;
    assign keyword_index = head.keyword_index;
    assign operator_char = head.operator_char;
    assign too_long      = head.too_long;
    assign last          = head.last;

endmodule

// ----- dv/tb_lexical_token_classifier_top.sv -----
// testbench for the byte-serial token classifier: directed text and random text
`timescale 1ns / 1ps

module tb_lexical_token_classifier_top;
    import ltc_pkg::*;

    localparam int TOKEN_MAX   = 49;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam string BREAK_CHARS = " ,;(){}[]=<>";
    localparam string WORD_CHARS  =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    // expected token stream and result checking
    class token_scoreboard;
        res_t        expected_q[$];
        int          mismatches;
        int          results_checked;
        int          overlong_seen;
        int          kind_seen[5];
        bit   [15:0] pos;
        bit   [15:0] tok_start;
        int unsigned tok_len;
        bit   [7:0]  prefix[6];
        bit          all_digits;
        bit          ident_first;
        bit          overflowed;
        string       keywords[8] = '{"int", "float", "if", "else", "while", "return",
                                     "char", "void"};

        function bit is_break_char(bit [7:0] c);
            for (int i = 0; i < BREAK_CHARS.len(); i++)
                if (BREAK_CHARS[i] == c)
                    return 1'b1;
            return 1'b0;
        endfunction

        function bit is_op_char(bit [7:0] c);
            return c == "+" || c == "-" || c == "*" || c == "/" ||
                   c == "=" || c == "<" || c == ">";
        endfunction

        function bit is_letter(bit [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_numeral(bit [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void clear_token();
            tok_len     = 0;
            all_digits  = 1'b1;
            ident_first = 1'b0;
            overflowed  = 1'b0;
            foreach (prefix[i])
                prefix[i] = 8'd0;
        endfunction

        function void reset_state();
            pos       = 16'd0;
            tok_start = 16'd0;
            clear_token();
        endfunction

        // work out the results caused by one transferred text byte
        function void note_byte(bit [7:0] c);
            res_t item;
            bit   hit;
            bit   has_op;
            int   kw_sel;
            hit    = 1'b0;
            kw_sel = 0;
            has_op = c != 8'd0 && is_op_char(c);

            // ordinary character grows the token
            if (c != 8'd0 && !is_break_char(c))
            begin
                if (tok_len == 0)
                begin
                    tok_start   = pos;
                    ident_first = is_letter(c) || c == "_";
                end
                if (tok_len < 6)
                    prefix[tok_len] = c;
                if (!is_numeral(c))
                    all_digits = 1'b0;
                if (tok_len < TOKEN_MAX)
                    tok_len++;
                else
                    overflowed = 1'b1;
                pos++;
                return;
            end

            // close a pending token
            if (tok_len != 0)
            begin
                if (!overflowed)
                begin
                    for (int k = 0; k < 8 && !hit; k++)
                    begin
                        if (keywords[k].len() != tok_len)
                            continue;
                        hit = 1'b1;
                        for (int j = 0; j < keywords[k].len(); j++)
                            if (keywords[k][j] != prefix[j])
                                hit = 1'b0;
                        if (hit)
                            kw_sel = k;
                    end
                end
                item               = '0;
                item.token_start   = tok_start;
                item.token_length  = 6'(tok_len);
                item.keyword_index = 3'(kw_sel);
                item.too_long      = overflowed;
                item.last          = !has_op;
                if (hit)
                    item.kind = KIND_KEYWORD;
                else if (all_digits)
                    item.kind = KIND_INTEGER;
                else if (ident_first)
                    item.kind = KIND_IDENTIFIER;
                else
                    item.kind = KIND_INVALID;
                expected_q.push_back(item);
            end

            // delimiter that doubles as an operator
            if (has_op)
            begin
                item               = '0;
                item.kind          = KIND_OPERATOR;
                item.token_start   = pos;
                item.token_length  = 6'd1;
                item.operator_char = c;
                item.last          = 1'b1;
                expected_q.push_back(item);
            end

            clear_token();
            if (c == 8'd0)
                pos = 16'd0;
            else
                pos++;
        endfunction

        task report_mismatch(string what, longint unsigned got_v, longint unsigned exp_v);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                         $time, results_checked, what, got_v, exp_v);
        endtask

        // compare one transferred result with the oldest expectation
        task check_result(res_t got);
            res_t exp_r;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result, kind", got.kind, 0);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.kind !== exp_r.kind)
                report_mismatch("kind", got.kind, exp_r.kind);
            if (got.token_start !== exp_r.token_start)
                report_mismatch("token_start", got.token_start, exp_r.token_start);
            if (got.token_length !== exp_r.token_length)
                report_mismatch("token_length", got.token_length, exp_r.token_length);
            if (got.keyword_index !== exp_r.keyword_index)
                report_mismatch("keyword_index", got.keyword_index, exp_r.keyword_index);
            if (got.operator_char !== exp_r.operator_char)
                report_mismatch("operator_char", got.operator_char, exp_r.operator_char);
            if (got.too_long !== exp_r.too_long)
                report_mismatch("too_long", got.too_long, exp_r.too_long);
            if (got.last !== exp_r.last)
                report_mismatch("last", got.last, exp_r.last);
            results_checked++;
            kind_seen[exp_r.kind]++;
            if (exp_r.too_long)
                overlong_seen++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        text_valid;
    logic        text_ready;
    logic [7:0]  text_byte;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  kind;
    logic [15:0] token_start;
    logic [5:0]  token_length;
    logic [2:0]  keyword_index;
    logic [7:0]  operator_char;
    logic        too_long;
    logic        last;

    token_scoreboard sb;
    bit              steady;
    int              cycles;
    int              bytes_sent;
    bit [7:0]        text_q[$];

    lexical_token_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_valid    (text_valid),
        .text_ready    (text_ready),
        .text_byte     (text_byte),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .token_start   (token_start),
        .token_length  (token_length),
        .keyword_index (keyword_index),
        .operator_char (operator_char),
        .too_long      (too_long),
        .last          (last)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, sb.expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random non-zero byte that does not close a token
    function automatic bit [7:0] plain_byte();
        bit [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (sb.is_break_char(c));
        return c;
    endfunction

    // append roughly n bytes of token-shaped text, each word followed by separators or the terminator
    function automatic void append_text(int n, bit allow_zero);
        int    target;
        int    pick;
        int    len;
        bit    numeric;
        string word;
        target = text_q.size() + n;
        while (text_q.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                word = sb.keywords[$urandom_range(0, 7)];
                for (int i = 0; i < word.len(); i++)
                    text_q.push_back(word[i]);
            end
            else if (pick < 48)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                    text_q.push_back(8'("0" + $urandom_range(0, 9)));
            end
            else if (pick < 72)
            begin
                len = $urandom_range(1, 8);
                text_q.push_back($urandom_range(0, 4) == 0 ? 8'("_") :
                                 8'(WORD_CHARS[$urandom_range(0, 51)]));
                repeat (len - 1)
                    text_q.push_back(WORD_CHARS[$urandom_range(0, 62)]);
            end
            else if (pick < 84)
            begin
                // arbitrary bytes, high half and arithmetic signs included
                len = $urandom_range(1, 8);
                repeat (len)
                    text_q.push_back(plain_byte());
            end
            else if (pick < 88)
            begin
                // length around the saturation limit
                case ($urandom_range(0, 4))
                    0: len = TOKEN_MAX - 1;
                    1: len = TOKEN_MAX;
                    2: len = TOKEN_MAX + 1;
                    3: len = TOKEN_MAX + 2;
                    default: len = $urandom_range(TOKEN_MAX + 3, 80);
                endcase
                numeric = 1'($urandom_range(0, 1));
                repeat (len)
                    text_q.push_back(numeric ? 8'("0" + $urandom_range(0, 9)) :
                                     8'(WORD_CHARS[$urandom_range(0, 62)]));
            end
            else
            begin
                // noise: any byte at all
                len = $urandom_range(1, 4);
                repeat (len)
                    text_q.push_back(allow_zero ? 8'($urandom_range(0, 255)) :
                                     8'($urandom_range(1, 255)));
            end

            // separators, sometimes the terminator
            if (allow_zero && $urandom_range(0, 19) == 0)
                text_q.push_back(8'd0);
            else
                repeat ($urandom_range(1, 2))
                    text_q.push_back(BREAK_CHARS[$urandom_range(0, 11)]);
        end
    endfunction

    // one text transfer; called and returning at a falling edge
    task automatic send_byte(bit [7:0] c);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= c;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        sb.note_byte(c);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());
    endtask

    // result side: random stalls, check every transfer
    initial
    begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            sb.check_result('{kind, token_start, token_length, keyword_index,
                              operator_char, too_long, last});
            @(negedge clk);
        end
    end

    // stimulus and end of run
    initial
    begin
        string directed;
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text_byte  = 8'd0;
        steady     = 1'b0;
        sb         = new();
        sb.reset_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: operators after tokens, digit-led invalid, empty tokens,
        // arithmetic signs inside a token, high byte, terminator with and without a token
        directed = "if=_a9<12>9a,,x-1*/;(){}[]";
        for (int i = 0; i < directed.len(); i++)
            text_q.push_back(directed[i]);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        text_q.push_back(8'h00);
        send_text();

        // random text in chunks, some chunks without any idling
        while (bytes_sent < 950)
        begin
            steady = $urandom_range(0, 3) == 0;
            append_text(100, 1'b1);
            send_text();
        end
        steady = 1'b0;
        text_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch("results never seen, count", sb.expected_q.size(), 0);

        $display("sent %0d text bytes, checked %0d results: %0d keyword %0d integer",
                 bytes_sent, sb.results_checked, sb.kind_seen[KIND_KEYWORD],
                 sb.kind_seen[KIND_INTEGER]);
        $display("%0d identifier %0d invalid %0d operator, %0d over-long, %0d mismatches",
                 sb.kind_seen[KIND_IDENTIFIER], sb.kind_seen[KIND_INVALID],
                 sb.kind_seen[KIND_OPERATOR], sb.overlong_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
